// File: design/cot_pkg.sv
// Shared types and constants for the collider overlap test unit.
package cot_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ID_BITS_DEF    = 16;
    localparam int DATA_BITS      = 32;
    localparam int PADDR_BITS     = 5;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_SOURCE_KIND   = 3'd0,
        REG_SOURCE_POS_X  = 3'd1,
        REG_SOURCE_POS_Y  = 3'd2,
        REG_SOURCE_POS_Z  = 3'd3,
        REG_SOURCE_SIZE_X = 3'd4,
        REG_SOURCE_SIZE_Y = 3'd5,
        REG_SOURCE_SIZE_Z = 3'd6,
        REG_SOURCE_RADIUS = 3'd7
    } cfg_reg_t;

    // Pair of collider kinds: upper bit is the source, lower bit the other one.
    typedef enum logic [1:0] {
        PAIR_BOX_BOX = 2'b00,
        PAIR_BOX_SPH = 2'b01,
        PAIR_SPH_BOX = 2'b10,
        PAIR_SPH_SPH = 2'b11
    } pair_t;

    // Load enables of the pipeline stages.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } stage_en_t;

endpackage

// File: design/cot_axis.sv
// One axis of the overlap datapath: bounds, overlap flag, clamped distance and its square.
module cot_axis
    import cot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  stage_en_t                      en,
    input  pair_t                          mode_b,
    input  logic signed [COORD_BITS-1:0]   src_pos,
    input  logic        [COORD_BITS-2:0]   src_size,
    input  logic signed [COORD_BITS-1:0]   oth_pos,
    input  logic        [COORD_BITS-2:0]   oth_size,
    output logic                           overlap,
    output logic        [2*COORD_BITS+1:0] dist_sq
);

    localparam int EW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;
    localparam int MW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] pos_a_reg;
    logic        [COORD_BITS-2:0] size_a_reg;

    logic signed [EW-1:0] src_ctr;
    logic signed [EW-1:0] src_lo;
    logic signed [EW-1:0] src_hi;
    logic signed [EW-1:0] oth_ctr;
    logic signed [EW-1:0] oth_ext;

    logic signed [EW-1:0] ctr_b_reg;
    logic signed [EW-1:0] lo_b_reg;
    logic signed [EW-1:0] hi_b_reg;

    logic signed [EW-1:0] sel_lo;
    logic signed [EW-1:0] sel_hi;
    logic signed [EW-1:0] sel_c;
    logic signed [DW-1:0] d_lo;
    logic signed [DW-1:0] d_hi;
    logic                 overlap_next;
    logic        [MW-1:0] mag_next;
    logic                 overlap_c_reg;
    logic        [MW-1:0] mag_c_reg;

    logic                      overlap_d_reg;
    logic [2*COORD_BITS+1:0]   sq_d_reg;

    // Doubled coordinates: a box spans [2p - s, 2p + s].
    assign src_ctr = $signed({src_pos[COORD_BITS-1], src_pos, 1'b0});
    assign src_lo  = src_ctr - $signed({3'b000, src_size});
    assign src_hi  = src_ctr + $signed({3'b000, src_size});
    assign oth_ctr = $signed({pos_a_reg[COORD_BITS-1], pos_a_reg, 1'b0});
    assign oth_ext = $signed({3'b000, size_a_reg});

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            pos_a_reg  <= oth_pos;
            size_a_reg <= oth_size;
        end
        if (en.b)
        begin
            ctr_b_reg <= oth_ctr;
            lo_b_reg  <= oth_ctr - oth_ext;
            hi_b_reg  <= oth_ctr + oth_ext;
        end
        if (en.c)
        begin
            overlap_c_reg <= overlap_next;
            mag_c_reg     <= mag_next;
        end
        if (en.d)
        begin
            overlap_d_reg <= overlap_c_reg;
            sq_d_reg      <= mag_c_reg * mag_c_reg;
        end
    end

    // A sphere against a sphere is a clamp onto a box of zero size at the
    // source centre, which yields the plain centre distance.
    always_comb
    begin
        case (mode_b)
            PAIR_SPH_SPH:
            begin
                sel_lo = src_ctr;
                sel_hi = src_ctr;
                sel_c  = ctr_b_reg;
            end
            PAIR_BOX_SPH:
            begin
                sel_lo = src_lo;
                sel_hi = src_hi;
                sel_c  = ctr_b_reg;
            end
            default:
            begin
                sel_lo = lo_b_reg;
                sel_hi = hi_b_reg;
                sel_c  = src_ctr;
            end
        endcase
    end

    assign d_lo = $signed({sel_lo[EW-1], sel_lo}) - $signed({sel_c[EW-1], sel_c});
    assign d_hi = $signed({sel_c[EW-1], sel_c}) - $signed({sel_hi[EW-1], sel_hi});

    always_comb
    begin
        if (!d_lo[DW-1] && (d_lo != '0))
            mag_next = d_lo[MW-1:0];
        else if (!d_hi[DW-1] && (d_hi != '0))
            mag_next = d_hi[MW-1:0];
        else
            mag_next = '0;
    end

    // Touching faces count as overlap.
    assign overlap_next = (src_lo <= hi_b_reg) && (src_hi >= lo_b_reg);

    assign overlap = overlap_d_reg;
    assign dist_sq = sq_d_reg;

endmodule

// File: design/collider_overlap_test_unit.sv
// Top level of the collider overlap test: register port, pipeline control and the final compare.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------------
//  other    | other_valid / other_stall       | other_kind, other_pos_*, other_size_*,
//           |                                 | other_radius, other_id, list_end
//  result   | result_valid / result_stall     | hit, hit_id, result_end
//  config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One beat is taken per cycle while other_stall is low.
// Each beat passes through five register stages: input, bounds, clamp, square, compare.
// Each stage loads whenever it is empty or the stage after it moves, so a stall on the
// result side fills the empty stages first and only then raises other_stall.
// Reset clears all valid bits and the source registers; nothing else needs clearing.
module collider_overlap_test_unit
    import cot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_BITS-1:0]        paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,

    input  logic                         other_valid,
    output logic                         other_stall,
    input  logic                         other_kind,
    input  logic signed [COORD_BITS-1:0] other_pos_x,
    input  logic signed [COORD_BITS-1:0] other_pos_y,
    input  logic signed [COORD_BITS-1:0] other_pos_z,
    input  logic [COORD_BITS-2:0]        other_size_x,
    input  logic [COORD_BITS-2:0]        other_size_y,
    input  logic [COORD_BITS-2:0]        other_size_z,
    input  logic [COORD_BITS-2:0]        other_radius,
    input  logic [ID_BITS-1:0]           other_id,
    input  logic                         list_end,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         hit,
    output logic [ID_BITS-1:0]           hit_id,
    output logic                         result_end
);

    localparam int RW = COORD_BITS + 1;
    localparam int SW = 2 * COORD_BITS + 2;
    localparam int TW = 2 * COORD_BITS + 4;

    // Source collider registers.
    logic                         src_kind_reg;
    logic signed [COORD_BITS-1:0] src_pos_x_reg;
    logic signed [COORD_BITS-1:0] src_pos_y_reg;
    logic signed [COORD_BITS-1:0] src_pos_z_reg;
    logic [COORD_BITS-2:0]        src_size_x_reg;
    logic [COORD_BITS-2:0]        src_size_y_reg;
    logic [COORD_BITS-2:0]        src_size_z_reg;
    logic [COORD_BITS-2:0]        src_radius_reg;

    cfg_reg_t cfg_index;
    logic     cfg_write;

    stage_en_t en;
    logic      en_out;
    logic      accept;

    logic va_reg, vb_reg, vc_reg, vd_reg, vout_reg;

    pair_t                 mode_a_reg, mode_b_reg, mode_c_reg, mode_d_reg;
    logic [COORD_BITS-2:0] rad_a_reg;
    logic [RW-1:0]         rterm_next;
    logic [RW-1:0]         rterm_b_reg, rterm_c_reg;
    logic [SW-1:0]         rsq_d_reg;
    logic [COORD_BITS-1:0] rsum;
    logic [ID_BITS-1:0]    id_a_reg, id_b_reg, id_c_reg, id_d_reg;
    logic                  end_a_reg, end_b_reg, end_c_reg, end_d_reg;

    logic              ovl_x, ovl_y, ovl_z;
    logic [SW-1:0]     sq_x, sq_y, sq_z;
    logic [TW-1:0]     dist_sum;
    logic              hit_next;
    logic              hit_reg;
    logic [ID_BITS-1:0] hit_id_reg;
    logic              result_end_reg;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = cfg_reg_t'(paddr[PADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_kind_reg   <= 1'b0;
            src_pos_x_reg  <= '0;
            src_pos_y_reg  <= '0;
            src_pos_z_reg  <= '0;
            src_size_x_reg <= '0;
            src_size_y_reg <= '0;
            src_size_z_reg <= '0;
            src_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_KIND:   src_kind_reg   <= pwdata[0];
                REG_SOURCE_POS_X:  src_pos_x_reg  <= pwdata[COORD_BITS-1:0];
                REG_SOURCE_POS_Y:  src_pos_y_reg  <= pwdata[COORD_BITS-1:0];
                REG_SOURCE_POS_Z:  src_pos_z_reg  <= pwdata[COORD_BITS-1:0];
                REG_SOURCE_SIZE_X: src_size_x_reg <= pwdata[COORD_BITS-2:0];
                REG_SOURCE_SIZE_Y: src_size_y_reg <= pwdata[COORD_BITS-2:0];
                REG_SOURCE_SIZE_Z: src_size_z_reg <= pwdata[COORD_BITS-2:0];
                REG_SOURCE_RADIUS: src_radius_reg <= pwdata[COORD_BITS-2:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_SOURCE_KIND:   prdata[0]              = src_kind_reg;
            REG_SOURCE_POS_X:  prdata[COORD_BITS-1:0] = src_pos_x_reg;
            REG_SOURCE_POS_Y:  prdata[COORD_BITS-1:0] = src_pos_y_reg;
            REG_SOURCE_POS_Z:  prdata[COORD_BITS-1:0] = src_pos_z_reg;
            REG_SOURCE_SIZE_X: prdata[COORD_BITS-2:0] = src_size_x_reg;
            REG_SOURCE_SIZE_Y: prdata[COORD_BITS-2:0] = src_size_y_reg;
            REG_SOURCE_SIZE_Z: prdata[COORD_BITS-2:0] = src_size_z_reg;
            REG_SOURCE_RADIUS: prdata[COORD_BITS-2:0] = src_radius_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when its successor moves.
    // ------------------------------------------------------------------
    assign en_out = !vout_reg || !result_stall;
    assign en.d   = !vd_reg || en_out;
    assign en.c   = !vc_reg || en.d;
    assign en.b   = !vb_reg || en.c;
    assign en.a   = !va_reg || en.b;

    assign other_stall = !en.a;
    assign accept      = other_valid && en.a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en.a)
                va_reg <= accept;
            if (en.b)
                vb_reg <= va_reg;
            if (en.c)
                vc_reg <= vb_reg;
            if (en.d)
                vd_reg <= vc_reg;
            if (en_out)
                vout_reg <= vd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Side channel: kinds, radius term, id and list end travel with the beat.
    // ------------------------------------------------------------------
    assign rsum = {1'b0, src_radius_reg} + {1'b0, rad_a_reg};

    always_comb
    begin
        case (mode_a_reg)
            PAIR_SPH_SPH: rterm_next = {rsum, 1'b0};
            PAIR_SPH_BOX: rterm_next = {1'b0, src_radius_reg, 1'b0};
            PAIR_BOX_SPH: rterm_next = {1'b0, rad_a_reg, 1'b0};
            default:      rterm_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            mode_a_reg <= pair_t'({src_kind_reg, other_kind});
            rad_a_reg  <= other_radius;
            id_a_reg   <= other_id;
            end_a_reg  <= list_end;
        end
        if (en.b)
        begin
            mode_b_reg  <= mode_a_reg;
            rterm_b_reg <= rterm_next;
            id_b_reg    <= id_a_reg;
            end_b_reg   <= end_a_reg;
        end
        if (en.c)
        begin
            mode_c_reg  <= mode_b_reg;
            rterm_c_reg <= rterm_b_reg;
            id_c_reg    <= id_b_reg;
            end_c_reg   <= end_b_reg;
        end
        if (en.d)
        begin
            mode_d_reg <= mode_c_reg;
            rsq_d_reg  <= rterm_c_reg * rterm_c_reg;
            id_d_reg   <= id_c_reg;
            end_d_reg  <= end_c_reg;
        end
        if (en_out)
        begin
            hit_reg        <= hit_next;
            hit_id_reg     <= id_d_reg;
            result_end_reg <= end_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Per-axis datapath
    // ------------------------------------------------------------------
    cot_axis #(.COORD_BITS(COORD_BITS)) u_axis_x
    (
        .clk      (clk),
        .en       (en),
        .mode_b   (mode_b_reg),
        .src_pos  (src_pos_x_reg),
        .src_size (src_size_x_reg),
        .oth_pos  (other_pos_x),
        .oth_size (other_size_x),
        .overlap  (ovl_x),
        .dist_sq  (sq_x)
    );

    cot_axis #(.COORD_BITS(COORD_BITS)) u_axis_y
    (
        .clk      (clk),
        .en       (en),
        .mode_b   (mode_b_reg),
        .src_pos  (src_pos_y_reg),
        .src_size (src_size_y_reg),
        .oth_pos  (other_pos_y),
        .oth_size (other_size_y),
        .overlap  (ovl_y),
        .dist_sq  (sq_y)
    );

    cot_axis #(.COORD_BITS(COORD_BITS)) u_axis_z
    (
        .clk      (clk),
        .en       (en),
        .mode_b   (mode_b_reg),
        .src_pos  (src_pos_z_reg),
        .src_size (src_size_z_reg),
        .oth_pos  (other_pos_z),
        .oth_size (other_size_z),
        .overlap  (ovl_z),
        .dist_sq  (sq_z)
    );

    // Spheres hit only when the squared distance is strictly below the squared radius.
    assign dist_sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    assign hit_next = (mode_d_reg == PAIR_BOX_BOX) ? (ovl_x && ovl_y && ovl_z)
                                                   : (dist_sum < {2'b00, rsq_d_reg});

    assign result_valid = vout_reg;
    assign hit          = hit_reg;
    assign hit_id       = hit_id_reg;
    assign result_end   = result_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        other_stall |-> (va_reg && vb_reg && vc_reg && vd_reg && vout_reg))
        else $error("input stalled while a stage is empty");

    a_drain_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (vout_reg && !result_stall && !vd_reg) |=> !vout_reg)
        else $error("result repeated after it was taken");

    a_stage_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg && !en.d) |=> (vc_reg && $stable(id_c_reg) && $stable(mode_c_reg)))
        else $error("held stage lost its beat");

    a_zero_spheres_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (en_out && vd_reg && mode_d_reg == PAIR_SPH_SPH && rsq_d_reg == '0) |=> !hit_reg)
        else $error("spheres of zero radius reported a hit");

endmodule
